// File: src/bmi_pkg.sv
// shared types and constants of the bitmap index query engine
package bmi_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAP_COUNT = 8;
    localparam int ROW_W     = 6;
    localparam int MAP_W     = 3;
    localparam int CNT_W     = 7;
    localparam int MAP_AW    = $clog2(MAP_COUNT);
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    typedef logic [MAX_ROWS-1:0] row_word_t;

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_EQ,
        CMD_AND,
        CMD_OR
    } cmd_t;

    typedef enum logic [1:0] {
        ST_MATCH,
        ST_NONE,
        ST_NOTFOUND
    } status_t;

    typedef enum logic [1:0] {
        LD_FIRST,
        LD_AND,
        LD_OR
    } load_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_LOAD_A,
        S_LOAD_B,
        S_CHECK,
        S_SCAN,
        S_SINGLE
    } state_t;

    typedef struct packed {
        logic  load;
        load_t mode;
        logic  shift;
    } scan_ctl_t;

    typedef struct packed {
        logic             zero;
        logic             bit0;
        logic             rest_zero;
        logic [ROW_W-1:0] row;
    } scan_stat_t;

endpackage

// File: src/bmi_ram.sv
// generic single write port ram with registered read
module bmi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bmi_scan.sv
// shared combine and shift unit that walks a result word one row per cycle while its shift control is set
module bmi_scan (
    input  logic                aclk,
    input  bmi_pkg::scan_ctl_t  ctl,
    input  bmi_pkg::row_word_t  rdata,
    input  bmi_pkg::row_word_t  mask,
    output bmi_pkg::scan_stat_t stat
);
    import bmi_pkg::*;

    row_word_t        word_reg, word_next;
    logic [ROW_W-1:0] row_reg, row_next;

    always_comb begin
        word_next = word_reg;
        row_next  = row_reg;
        if (ctl.load) begin
            row_next = '0;
            unique case (ctl.mode)
                LD_FIRST: word_next = rdata & mask;
                LD_AND:   word_next = word_reg & rdata & mask;
                LD_OR:    word_next = (word_reg | rdata) & mask;
                default:  word_next = rdata & mask;
            endcase
        end else if (ctl.shift) begin
            word_next = word_reg >> 1;
            row_next  = row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        row_reg  <= row_next;
    end

    assign stat.zero      = (word_reg == '0);
    assign stat.bit0      = word_reg[0];
    assign stat.rest_zero = (word_reg[MAX_ROWS-1:1] == '0);
    assign stat.row       = row_reg;

endmodule

// File: src/bmi_ctrl.sv
// sequencer: command decode, bitmap read and update, result output register
module bmi_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bmi_pkg::cmd_t                cmd,
    input  logic [bmi_pkg::MAP_W-1:0]    first_map,
    input  logic [bmi_pkg::MAP_W-1:0]    second_map,
    input  logic [bmi_pkg::ROW_W-1:0]    row_index,
    input  logic                         bit_value,
    input  logic [bmi_pkg::CNT_W-1:0]    row_lim,
    output logic                         ram_we,
    output logic [bmi_pkg::MAP_AW-1:0]   ram_waddr,
    output bmi_pkg::row_word_t           ram_wdata,
    output logic [bmi_pkg::MAP_AW-1:0]   ram_raddr,
    input  bmi_pkg::row_word_t           ram_rdata,
    output bmi_pkg::scan_ctl_t           scan_ctl,
    input  bmi_pkg::scan_stat_t          scan_stat,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bmi_pkg::status_t             m_status,
    output logic [bmi_pkg::ROW_W-1:0]    m_row,
    output logic                         m_last
);
    import bmi_pkg::*;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [MAP_W-1:0]     m1_reg, m2_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 bit_reg;
    logic [MAP_COUNT-1:0] present_reg, present_next;
    status_t              single_reg, single_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic                 out_last_reg, out_last_next;

    logic      m1_ok, m2_ok, exists1, exists2, slot_free, emit;
    row_word_t old_word, bit_mask;

    assign m1_ok     = (int'(m1_reg) < MAP_COUNT);
    assign m2_ok     = (int'(m2_reg) < MAP_COUNT);
    assign exists1   = m1_ok && present_reg[m1_reg[MAP_AW-1:0]];
    assign exists2   = m2_ok && present_reg[m2_reg[MAP_AW-1:0]];
    assign slot_free = !out_valid_reg || m_ready;
    assign old_word  = exists1 ? ram_rdata : '0;
    assign bit_mask  = row_word_t'(1) << row_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (cmd_reg == CMD_SET) begin
                    state_next = (m1_ok && (CNT_W'(row_reg) < row_lim)) ? S_RD_A : S_IDLE;
                end else if (exists1 && (cmd_reg == CMD_EQ || exists2)) begin
                    state_next = S_RD_A;
                end else begin
                    state_next = S_SINGLE;
                end
            end
            S_RD_A: state_next = S_LOAD_A;
            S_LOAD_A: begin
                unique case (cmd_reg)
                    CMD_SET: state_next = S_IDLE;
                    CMD_EQ:  state_next = S_CHECK;
                    default: state_next = S_LOAD_B;
                endcase
            end
            S_LOAD_B: state_next = S_CHECK;
            S_CHECK:  state_next = scan_stat.zero ? S_SINGLE : S_SCAN;
            S_SCAN: begin
                if (scan_stat.bit0 && slot_free && scan_stat.rest_zero) begin
                    state_next = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == S_IDLE);
        ram_we         = (state_reg == S_LOAD_A) && (cmd_reg == CMD_SET);
        ram_waddr      = m1_reg[MAP_AW-1:0];
        ram_wdata      = bit_reg ? (old_word | bit_mask) : (old_word & ~bit_mask);
        ram_raddr      = (state_reg == S_LOAD_A) ? m2_reg[MAP_AW-1:0] : m1_reg[MAP_AW-1:0];
        scan_ctl.load  = 1'b0;
        scan_ctl.mode  = LD_FIRST;
        scan_ctl.shift = 1'b0;
        emit           = 1'b0;
        present_next   = present_reg;
        single_next    = single_reg;
        out_status_next = ST_MATCH;
        out_row_next    = '0;
        out_last_next   = 1'b1;
        unique case (state_reg)
            S_DECODE: begin
                single_next = ST_NOTFOUND;
            end
            S_LOAD_A: begin
                if (cmd_reg == CMD_SET) begin
                    present_next[m1_reg[MAP_AW-1:0]] = 1'b1;
                end else begin
                    scan_ctl.load = 1'b1;
                end
            end
            S_LOAD_B: begin
                scan_ctl.load = 1'b1;
                scan_ctl.mode = (cmd_reg == CMD_AND) ? LD_AND : LD_OR;
            end
            S_CHECK: begin
                single_next = ST_NONE;
            end
            S_SCAN: begin
                scan_ctl.shift = !scan_stat.bit0 || slot_free;
                emit           = scan_stat.bit0 && slot_free;
                out_row_next   = scan_stat.row;
                out_last_next  = scan_stat.rest_zero;
            end
            S_SINGLE: begin
                emit            = slot_free;
                out_status_next = single_reg;
            end
            default: begin
            end
        endcase
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        single_reg <= single_next;
        if (s_valid && s_ready) begin
            cmd_reg <= cmd;
            m1_reg  <= first_map;
            m2_reg  <= second_map;
            row_reg <= row_index;
            bit_reg <= bit_value;
        end
        if (emit) begin
            out_status_reg <= out_status_next;
            out_row_reg    <= out_row_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_row    = out_row_reg;
    assign m_last   = out_last_reg;

endmodule

// File: src/bitmap_index_query_engine.sv
// top level of the bitmap index query engine
// set request: bitmap read, then written with the bit updated; next request taken after the write
// ignored set request (row at or beyond row count): next request taken straight after decode
// query: not-found result registered in the single-result state after decode, else first result
// registered after the read, load and check states and the scan up to the first matching row;
// the scan walks one row per cycle; stalled results hold the scan
// reset (aresetn low, synchronous) marks all bitmaps absent and sets row_count to 64
module bitmap_index_query_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_map [2:0], second_map [5:3], row_index [11:6], bit_value [12]
    input  logic [bmi_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match_row [5:0]
    output logic [bmi_pkg::M_DATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmi_pkg::CNT_W-1:0]      cfg_data
);
    import bmi_pkg::*;

    logic [CNT_W-1:0]  row_count_reg;
    logic [CNT_W-1:0]  row_lim;
    row_word_t         row_mask;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr, ram_raddr;
    row_word_t         ram_wdata, ram_rdata;
    scan_ctl_t         scan_ctl;
    scan_stat_t        scan_stat;
    status_t           m_status;
    logic [ROW_W-1:0]  m_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CNT_W'(MAX_ROWS);
        end else if (cfg_valid) begin
            row_count_reg <= cfg_data;
        end
    end

    assign row_lim  = (row_count_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_reg;
    assign row_mask = (row_lim >= CNT_W'(MAX_ROWS)) ? '1
                    : ((row_word_t'(1) << row_lim) - row_word_t'(1));

    bmi_ram #(
        .WIDTH(MAX_ROWS),
        .DEPTH(MAP_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmi_scan u_scan (
        .aclk  (aclk),
        .ctl   (scan_ctl),
        .rdata (ram_rdata),
        .mask  (row_mask),
        .stat  (scan_stat)
    );

    bmi_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .cmd        (cmd_t'(s_tuser)),
        .first_map  (s_tdata[2:0]),
        .second_map (s_tdata[5:3]),
        .row_index  (s_tdata[11:6]),
        .bit_value  (s_tdata[12]),
        .row_lim    (row_lim),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .scan_ctl   (scan_ctl),
        .scan_stat  (scan_stat),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (m_status),
        .m_row      (m_row),
        .m_last     (m_tlast)
    );

    assign m_tuser = m_status;
    assign m_tdata = M_DATA_W'(m_row);

endmodule

// File: src/bmi_checker.sv
// port level checks of the bitmap index query engine
module bmi_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bmi_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import bmi_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_MATCH |-> m_tlast && m_tdata == '0)
        else $error("no-match or not-found result malformed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_ascend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser == ST_MATCH
            |=> !m_tvalid || (m_tuser == ST_MATCH && m_tdata > $past(m_tdata)))
        else $error("match rows not ascending");

endmodule

bind bitmap_index_query_engine bmi_checker u_bmi_checker (.*);

// File: test/tb_bitmap_index_query_engine.sv
`timescale 1ns / 100ps
// self-checking testbench for the bitmap index query engine with random stream stalls
module tb_bitmap_index_query_engine;
    import bmi_pkg::*;

    typedef struct {
        cmd_t       cmd;
        logic [2:0] first_map;
        logic [2:0] second_map;
        logic [5:0] row_index;
        logic       bit_value;
    } request_t;

    typedef struct {
        status_t    status;
        logic [5:0] match_row;
        logic       last;
    } hit_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;

    bitmap_index_query_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    row_word_t            map_rows [MAP_COUNT];
    logic [MAP_COUNT-1:0] map_seen;
    logic [CNT_W-1:0]     rows_cfg;

    request_t pending_reqs [$];
    hit_t     expected_hits [$];
    int       reqs_in_flight = 0;
    int       mismatches     = 0;
    bit       src_idle       = 1'b1;
    bit       sink_idle      = 1'b1;
    int       hold_asked     = 0;
    int       hold_done      = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic void apply_request(request_t r);
        int unsigned n;
        row_word_t   hits;
        hit_t        h;
        n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        if (r.cmd == CMD_SET) begin
            if (r.row_index < n) begin
                map_rows[r.first_map][r.row_index] = r.bit_value;
                map_seen[r.first_map] = 1'b1;
            end
            return;
        end
        if (!map_seen[r.first_map] || (r.cmd != CMD_EQ && !map_seen[r.second_map])) begin
            h = '{ST_NOTFOUND, 6'd0, 1'b1};
            expected_hits = {expected_hits, h};
            return;
        end
        case (r.cmd)
            CMD_EQ:  hits = map_rows[r.first_map];
            CMD_AND: hits = map_rows[r.first_map] & map_rows[r.second_map];
            default: hits = map_rows[r.first_map] | map_rows[r.second_map];
        endcase
        if (n < MAX_ROWS) hits = hits & ((row_word_t'(1) << n) - row_word_t'(1));
        if (hits == '0) begin
            h = '{ST_NONE, 6'd0, 1'b1};
            expected_hits = {expected_hits, h};
            return;
        end
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (hits[i]) begin
                h.status    = ST_MATCH;
                h.match_row = 6'(i);
                h.last      = ((hits >> (i + 1)) == '0);
                expected_hits = {expected_hits, h};
            end
        end
    endfunction

    task automatic add_req(cmd_t c, int fm, int sm, int row, int bv);
        request_t r;
        r.cmd        = c;
        r.first_map  = 3'(fm);
        r.second_map = 3'(sm);
        r.row_index  = 6'(row);
        r.bit_value  = 1'(bv);
        pending_reqs = {pending_reqs, r};
        reqs_in_flight++;
    endtask

    task automatic add_random(int count);
        int unsigned n;
        int unsigned row;
        n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        repeat (count) begin
            if ($urandom_range(0, 99) < 50) begin
                if (n > 0 && $urandom_range(0, 99) < 85) row = $urandom_range(0, n - 1);
                else row = $urandom_range(0, 63);
                add_req(CMD_SET, $urandom_range(0, 7), $urandom_range(0, 7), row,
                        $urandom_range(0, 99) < 70);
            end else begin
                add_req(cmd_t'($urandom_range(1, 3)), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 1));
            end
        end
    endtask

    task automatic wait_idle();
        while (reqs_in_flight > 0 || expected_hits.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_row_count(logic [CNT_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rows_cfg = v;
    endtask

    // request driver
    request_t cur_req;
    int       src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(cur_req);
                reqs_in_flight--;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {3'b000, cur_req.bit_value, cur_req.row_index,
                                cur_req.second_map, cur_req.first_map};
                    s_tuser <= cur_req.cmd;
                    s_tvalid <= 1'b1;
                    src_gap = src_idle ? idle_len() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int sink_gap  = 0;
    int sink_hold = 0;
    always @(posedge aclk) begin
        hit_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: status %0d row %0d last %0d",
                                 m_tuser, m_tdata[5:0], m_tlast);
                    mismatches++;
                end else begin
                    want = expected_hits.pop_front();
                    if (status_t'(m_tuser) !== want.status || m_tdata[5:0] !== want.match_row ||
                        m_tlast !== want.last) begin
                        if (mismatches < 10)
                            $display("result mismatch: want %0d %0d %0d, got %0d %0d %0d",
                                     want.status, want.match_row, want.last,
                                     m_tuser, m_tdata[5:0], m_tlast);
                        mismatches++;
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                sink_hold = 300;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = sink_idle ? idle_len() : 0;
            end
        end
    end

    initial begin
        for (int m = 0; m < MAP_COUNT; m++) map_rows[m] = '0;
        map_seen = '0;
        rows_cfg = CNT_W'(MAX_ROWS);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // queries on bitmaps never written, then writes to bitmap 0 and a query of it
        add_req(CMD_EQ, 0, 0, 0, 0);
        add_req(CMD_AND, 0, 1, 63, 1);
        add_req(CMD_OR, 2, 3, 0, 0);
        add_req(CMD_SET, 0, 7, 0, 1);
        add_req(CMD_SET, 0, 0, 63, 1);
        add_req(CMD_EQ, 0, 5, 17, 1);
        // existing but empty bitmap
        add_req(CMD_SET, 1, 0, 63, 0);
        add_req(CMD_EQ, 1, 0, 0, 0);
        add_req(CMD_AND, 0, 1, 0, 0);
        add_req(CMD_OR, 1, 0, 0, 0);
        add_req(CMD_AND, 0, 2, 0, 0);
        add_req(CMD_OR, 7, 0, 0, 0);
        add_req(CMD_SET, 7, 7, 5, 1);
        add_req(CMD_EQ, 7, 7, 63, 1);
        wait_idle();

        write_row_count(1);
        // write beyond row count
        add_req(CMD_SET, 3, 0, 1, 1);
        add_req(CMD_EQ, 3, 0, 0, 0);
        add_req(CMD_EQ, 0, 0, 0, 0);
        add_req(CMD_SET, 3, 0, 0, 0);
        add_req(CMD_AND, 3, 0, 0, 0);
        wait_idle();

        write_row_count(0);
        add_req(CMD_SET, 4, 0, 0, 1);
        add_req(CMD_EQ, 4, 0, 0, 0);
        add_req(CMD_OR, 0, 7, 0, 0);
        wait_idle();

        // row count above max, hidden rows come back
        write_row_count(127);
        add_req(CMD_OR, 0, 7, 0, 0);
        wait_idle();

        write_row_count(64);
        add_random(45);
        wait_idle();

        write_row_count(5);
        add_random(25);
        wait_idle();

        // long receiver hold while requests keep coming
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        write_row_count(100);
        hold_asked++;
        add_random(35);
        wait_idle();

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        write_row_count(2);
        add_random(20);
        wait_idle();

        write_row_count(64);
        add_random(22);
        wait_idle();

        repeat (80) @(posedge aclk);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
